// ===== hw/rtl/bor_pkg.sv =====
package bor_pkg;

  // default geometry of the block
  localparam int unsigned CoordBitsDef = 12;
  localparam int unsigned FracBitsDef  = 16;

  // number of bits a field group takes once padded to whole bytes
  function automatic int unsigned byte_pad(input int unsigned bits);
    return ((bits + 7) / 8) * 8;
  endfunction

endpackage

// ===== hw/rtl/bor_geom.sv =====
module bor_geom import bor_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [COORD_BITS-1:0]     first_x_i,
  input  logic [COORD_BITS-1:0]     first_y_i,
  input  logic [COORD_BITS-1:0]     first_w_i,
  input  logic [COORD_BITS-1:0]     first_h_i,
  input  logic [COORD_BITS-1:0]     second_x_i,
  input  logic [COORD_BITS-1:0]     second_y_i,
  input  logic [COORD_BITS-1:0]     second_w_i,
  input  logic [COORD_BITS-1:0]     second_h_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [2*COORD_BITS:0]     inter_o,
  output logic [2*COORD_BITS+1:0]   union_o
);

  localparam int unsigned EW = COORD_BITS + 1;     // far edges and spans
  localparam int unsigned AW = 2 * COORD_BITS + 2; // products
  localparam int unsigned IW = 2 * COORD_BITS + 1; // intersection
  localparam int unsigned UW = 2 * COORD_BITS + 2; // union

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // stage 1: edges and spans
  logic [COORD_BITS-1:0] ax0_q, ay0_q, bx0_q, by0_q;
  logic [EW-1:0] ax1_q, ay1_q, bx1_q, by1_q;
  logic [EW-1:0] aw1_q, ah1_q, bw1_q, bh1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      ax0_q <= first_x_i;
      ay0_q <= first_y_i;
      bx0_q <= second_x_i;
      by0_q <= second_y_i;
      ax1_q <= {1'b0, first_x_i} + {1'b0, first_w_i};
      ay1_q <= {1'b0, first_y_i} + {1'b0, first_h_i};
      bx1_q <= {1'b0, second_x_i} + {1'b0, second_w_i};
      by1_q <= {1'b0, second_y_i} + {1'b0, second_h_i};
      aw1_q <= {1'b0, first_w_i} + EW'(1);
      ah1_q <= {1'b0, first_h_i} + EW'(1);
      bw1_q <= {1'b0, second_w_i} + EW'(1);
      bh1_q <= {1'b0, second_h_i} + EW'(1);
    end
  end

  // stage 2: disjoint test and overlap spans
  logic [EW-1:0] lo_x, lo_y, hi_x, hi_y;
  logic          disj;

  always_comb begin
    lo_x = (ax1_q < bx1_q) ? ax1_q : bx1_q;
    lo_y = (ay1_q < by1_q) ? ay1_q : by1_q;
    hi_x = (ax0_q > bx0_q) ? {1'b0, ax0_q} : {1'b0, bx0_q};
    hi_y = (ay0_q > by0_q) ? {1'b0, ay0_q} : {1'b0, by0_q};
    disj = ({1'b0, ax0_q} > bx1_q) || ({1'b0, ay0_q} > by1_q) ||
           (ax1_q < {1'b0, bx0_q}) || (ay1_q < {1'b0, by0_q});
  end

  logic          disj2_q;
  logic [EW-1:0] cols2_q, rows2_q;
  logic [EW-1:0] aw2_q, ah2_q, bw2_q, bh2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      disj2_q <= disj;
      cols2_q <= lo_x - hi_x + EW'(1);
      rows2_q <= lo_y - hi_y + EW'(1);
      aw2_q   <= aw1_q;
      ah2_q   <= ah1_q;
      bw2_q   <= bw1_q;
      bh2_q   <= bh1_q;
    end
  end

  // stage 3: areas
  logic [AW-1:0] inter_prod, area_a_prod, area_b_prod;
  logic [IW-1:0] inter3_q;
  logic [AW-1:0] area_a3_q, area_b3_q;

  assign inter_prod  = AW'(cols2_q) * AW'(rows2_q);
  assign area_a_prod = AW'(aw2_q) * AW'(ah2_q);
  assign area_b_prod = AW'(bw2_q) * AW'(bh2_q);

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      inter3_q  <= disj2_q ? '0 : inter_prod[IW-1:0];
      area_a3_q <= area_a_prod;
      area_b3_q <= area_b_prod;
    end
  end

  // stage 4: union, never below one
  logic [IW-1:0] inter4_q;
  logic [UW-1:0] union4_q;

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      inter4_q <= inter3_q;
      union4_q <= UW'(area_a3_q) + UW'(area_b3_q) - UW'(inter3_q);
    end
  end

  assign out_valid_o = v4_q;
  assign inter_o     = inter4_q;
  assign union_o     = union4_q;

endmodule

// ===== hw/rtl/bor_div.sv =====
module bor_div import bor_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [2*COORD_BITS:0]   inter_i,
  input  logic [2*COORD_BITS+1:0] union_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [FRAC_BITS:0]      ratio_o
);

  localparam int unsigned UW = 2 * COORD_BITS + 2;
  localparam int unsigned QW = FRAC_BITS + 1;
  localparam int unsigned NS = FRAC_BITS + 1;

  logic          v_q   [NS];
  logic          rdy   [NS];
  logic [QW-1:0] quo_q [NS];
  logic [UW-1:0] rem_q [NS-1];
  logic [UW-1:0] uni_q [NS-1];

  // one quotient bit per stage, integer bit first; remainder stays below union
  for (genvar j = 0; j < NS; j++) begin : g_stage
    logic [UW:0]   trial;
    logic [UW-1:0] divisor;
    logic          qbit;
    logic [UW:0]   diff;
    logic          up_valid;

    if (j == 0) begin : g_first
      assign trial    = {1'b0, UW'(inter_i)};
      assign divisor  = union_i;
      assign up_valid = in_valid_i;
    end else begin : g_next
      assign trial    = {rem_q[j-1], 1'b0};
      assign divisor  = uni_q[j-1];
      assign up_valid = v_q[j-1];
    end

    if (j == NS - 1) begin : g_last
      assign rdy[j] = !v_q[j] || out_ready_i;
    end else begin : g_mid
      assign rdy[j] = !v_q[j] || rdy[j+1];
    end

    assign qbit = (trial >= {1'b0, divisor});
    assign diff = trial - (qbit ? {1'b0, divisor} : '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (rdy[j]) begin
        v_q[j] <= up_valid;
      end
    end

    if (j == 0) begin : g_q_first
      always_ff @(posedge clk_i) begin
        if (rdy[j]) quo_q[j] <= {{(QW-1){1'b0}}, qbit};
      end
    end else begin : g_q_next
      always_ff @(posedge clk_i) begin
        if (rdy[j]) quo_q[j] <= {quo_q[j-1][QW-2:0], qbit};
      end
    end

    if (j < NS - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (rdy[j]) begin
          rem_q[j] <= diff[UW-1:0];
          uni_q[j] <= divisor;
        end
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NS-1];
  assign ratio_o     = quo_q[NS-1];

endmodule

// ===== hw/rtl/box_overlap_ratio_unit.sv =====
// Intersection over union of two axis-aligned boxes, given as x, y, width and height,
// with spans counted inclusively (a box covers w+1 columns). The result is
// floor(overlap * 2^FRAC_BITS / union), 0 for disjoint boxes and 2^FRAC_BITS for
// identical ones. One box pair is accepted every cycle while the output is not stalled. The
// pipe is four geometry stages (edges, overlap spans, area multipliers, union) followed by a
// restoring divider that resolves one quotient bit per stage. Each stage holds its
// beat under back-pressure and empty stages keep taking new beats.
module box_overlap_ratio_unit import bor_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // first_x, first_y, first_w, first_h, second_x, second_y, second_w, second_h
  input  logic [byte_pad(8*COORD_BITS)-1:0]    s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // overlap_ratio
  output logic [byte_pad(FRAC_BITS+1)-1:0]     m_axis_tdata
);

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned OW  = byte_pad(FRAC_BITS + 1);
  localparam int unsigned QW  = FRAC_BITS + 1;

  logic                 g_valid, g_ready;
  logic [2*C:0]         g_inter;
  logic [2*C+1:0]       g_union;
  logic [QW-1:0]        ratio;

  bor_geom #(
    .COORD_BITS(COORD_BITS)
  ) u_geom (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .first_x_i  (s_axis_tdata[0*C +: C]),
    .first_y_i  (s_axis_tdata[1*C +: C]),
    .first_w_i  (s_axis_tdata[2*C +: C]),
    .first_h_i  (s_axis_tdata[3*C +: C]),
    .second_x_i (s_axis_tdata[4*C +: C]),
    .second_y_i (s_axis_tdata[5*C +: C]),
    .second_w_i (s_axis_tdata[6*C +: C]),
    .second_h_i (s_axis_tdata[7*C +: C]),
    .out_valid_o(g_valid),
    .out_ready_i(g_ready),
    .inter_o    (g_inter),
    .union_o    (g_union)
  );

  bor_div #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (g_valid),
    .in_ready_o (g_ready),
    .inter_i    (g_inter),
    .union_i    (g_union),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .ratio_o    (ratio)
  );

  assign m_axis_tdata = OW'(ratio);

  // the ratio can never exceed one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[QW-1:0] <= (QW'(1) << FRAC_BITS)))
    else $error("overlap ratio above one");

  // back-pressure at the input only comes from a full pipe stalled at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output stall");

  // geometry stage never hands on an empty union
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    g_valid |-> (g_union != '0) && ({1'b0, g_inter} <= g_union))
    else $error("union empty or below intersection");

endmodule
